// ===== src/arpc_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// arpc_pkg
// Shared constants, codes and types of the ARP cache and responder.
// ============================================================================
package arpc_pkg;

   localparam int BUCKETS     = 16;
   localparam int WAYS        = 4;
   localparam int MAX_RESULTS = 64;

   localparam int  SET_W        = $clog2(BUCKETS);
   localparam int  WAY_W        = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int  CNT_W        = $clog2(MAX_RESULTS + 1);
   localparam bit  BUCKETS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

   localparam logic [1:0] OP_PACKET = 2'd0;
   localparam logic [1:0] OP_QUERY  = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;
   localparam logic [1:0] OP_TICK   = 2'd3;

   localparam logic [15:0] OPER_REQUEST = 16'd1;
   localparam logic [15:0] OPER_REPLY   = 16'd2;

   localparam logic [2:0] K_LOOKUP   = 3'd0;
   localparam logic [2:0] K_REPLY    = 3'd1;
   localparam logic [2:0] K_RESOLVED = 3'd2;
   localparam logic [2:0] K_FAILED   = 3'd3;
   localparam logic [2:0] K_FULL     = 3'd4;
   localparam logic [2:0] K_PRESENT  = 3'd5;

   localparam logic [1:0] ST_ABSENT     = 2'd0;
   localparam logic [1:0] ST_INCOMPLETE = 2'd1;
   localparam logic [1:0] ST_RESOLVED   = 2'd2;
   localparam logic [1:0] ST_FAILED     = 2'd3;

   localparam logic [1:0] REG_OWN_IP      = 2'd0;
   localparam logic [1:0] REG_OWN_MAC     = 2'd1;
   localparam logic [1:0] REG_RETRY_COUNT = 2'd2;

   typedef struct packed {
      logic [31:0] ip;
      logic [47:0] mac;
      logic [1:0]  status;
      logic [3:0]  retries;
      logic        waiter;
   } entry_type;

   typedef entry_type [WAYS-1:0] row_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] arp_oper;
      logic [47:0] frame_src_mac;
      logic [47:0] sender_mac;
      logic [31:0] sender_ip;
      logic [31:0] tgt_ip;
      logic [31:0] query_ip;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [47:0] reply_target_mac;
      logic [31:0] reply_dst_ip;
      logic [31:0] entry_ip;
      logic [47:0] entry_mac;
      logic [1:0]  entry_state;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] own_ip;
      logic [47:0] own_mac;
      logic [3:0]  retry_count;
   } cfg_type;

endpackage

// ===== src/arpc_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// arpc_if
// Request, response and register write channels.
// ============================================================================
interface arpc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [15:0] arp_oper;
   logic [47:0] frame_src_mac;
   logic [47:0] sender_mac;
   logic [31:0] sender_ip;
   logic [31:0] tgt_ip;
   logic [31:0] query_ip;
   modport source (output valid, op, arp_oper, frame_src_mac, sender_mac, sender_ip,
                   tgt_ip, query_ip, input ready);
   modport sink (input valid, op, arp_oper, frame_src_mac, sender_mac, sender_ip,
                 tgt_ip, query_ip, output ready);
endinterface

interface arpc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [47:0] reply_target_mac;
   logic [31:0] reply_dst_ip;
   logic [31:0] entry_ip;
   logic [47:0] entry_mac;
   logic [1:0]  entry_state;
   logic        last;
   modport source (output valid, kind, reply_target_mac, reply_dst_ip, entry_ip,
                   entry_mac, entry_state, last, input ready);
   modport sink (input valid, kind, reply_target_mac, reply_dst_ip, entry_ip,
                 entry_mac, entry_state, last, output ready);
endinterface

interface arpc_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [47:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== src/arpc_cfg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// arpc_cfg
// Configuration registers: own IP, own MAC and retry count.
// ============================================================================
module arpc_cfg (
   input  logic             clock,
   input  logic             reset,
   arpc_csr_if.sink         csr,
   output arpc_pkg::cfg_type cfg
);

   arpc_pkg::cfg_type cfg_ff;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_ip      <= '0;
         cfg_ff.own_mac     <= '0;
         cfg_ff.retry_count <= 4'd7;
      end else if (csr.valid) begin
         unique case (csr.index)
            arpc_pkg::REG_OWN_IP:      cfg_ff.own_ip      <= csr.data[31:0];
            arpc_pkg::REG_OWN_MAC:     cfg_ff.own_mac     <= csr.data;
            arpc_pkg::REG_RETRY_COUNT: cfg_ff.retry_count <= csr.data[3:0];
            default: ;
         endcase
      end
   end

endmodule

// ===== src/arpc_set_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// arpc_set_ram
// Set memory: one row of all ways per set, registered read.
// ============================================================================
module arpc_set_ram (
   input  logic                         clock,
   input  logic                         we,
   input  logic [arpc_pkg::SET_W-1:0]   waddr,
   input  arpc_pkg::row_type            wdata,
   input  logic                         re,
   input  logic [arpc_pkg::SET_W-1:0]   raddr,
   output arpc_pkg::row_type            rdata
);

   arpc_pkg::row_type mem [arpc_pkg::BUCKETS];
   arpc_pkg::row_type rdata_ff;

   assign rdata = rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

endmodule

// ===== src/arp_cache_and_responder_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// arp_cache_and_responder_unit
// ARP table of set-associative entries with an ARP request responder.
// ============================================================================
//  channel | dir | carries
//  req     | in  | received ARP packet, resolve query, lookup or timer tick
//  rsp     | out | lookup answers, reply frames, notices; last marks the end
//  csr     | in  | own_ip (0), own_mac (1), retry_count (2)
//
//  Packet, query and lookup: accept, set reduction (only when BUCKETS is not a
//  power of two), set read, read-modify-write, result.
//  Tick: the walk reads, updates way by way and writes back each set of the
//  memory. A stalled rsp channel holds the walk.
//  Reset clears all valid bits at once; no clearing pass.
// ============================================================================
module arp_cache_and_responder_unit (
   input logic      clock,
   input logic      reset,
   arpc_req_if.sink req,
   arpc_rsp_if.source rsp,
   arpc_csr_if.sink csr
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MOD   = 3'd1;
   localparam logic [2:0] S_RD    = 3'd2;
   localparam logic [2:0] S_LOOK  = 3'd3;
   localparam logic [2:0] S_TLOAD = 3'd4;
   localparam logic [2:0] S_TWAY  = 3'd5;
   localparam logic [2:0] S_TWR   = 3'd6;
   localparam logic [2:0] S_FLUSH = 3'd7;

   localparam int REM_W = arpc_pkg::SET_W + 1;

   arpc_pkg::cfg_type cfg;

   logic [2:0]                  state_ff, state_in;
   arpc_pkg::req_type           req_ff, req_in;
   logic [arpc_pkg::SET_W-1:0]  set_ff, set_in;
   logic [arpc_pkg::WAY_W-1:0]  way_ff, way_in;
   logic [2:0]                  nib_ff, nib_in;
   logic [REM_W-1:0]            rem_ff, rem_in;
   arpc_pkg::row_type           row_ff, row_in;
   logic [arpc_pkg::BUCKETS-1:0][arpc_pkg::WAYS-1:0] valid_ff, valid_in;
   logic                        pend_valid_ff, pend_valid_in;
   arpc_pkg::rsp_type           pend_ff, pend_in;
   logic                        out_valid_ff, out_valid_in;
   arpc_pkg::rsp_type           out_ff, out_in;
   logic [arpc_pkg::CNT_W-1:0]  cnt_ff, cnt_in;

   logic                        ram_we, ram_re;
   arpc_pkg::row_type           ram_wdata, ram_rdata;

   arpc_cfg u_cfg (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .cfg   (cfg)
   );

   arpc_set_ram u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (set_ff),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (set_ff),
      .rdata (ram_rdata)
   );

   assign rsp.valid            = out_valid_ff;
   assign rsp.kind             = out_ff.kind;
   assign rsp.reply_target_mac = out_ff.reply_target_mac;
   assign rsp.reply_dst_ip     = out_ff.reply_dst_ip;
   assign rsp.entry_ip         = out_ff.entry_ip;
   assign rsp.entry_mac        = out_ff.entry_mac;
   assign rsp.entry_state      = out_ff.entry_state;
   assign rsp.last             = out_ff.last;

   logic                       out_free;
   logic [31:0]                key, new_key;
   logic [3:0]                 nibble;
   logic [REM_W-1:0]           rem_step;
   logic                       hit, has_free, emit;
   logic [arpc_pkg::WAY_W-1:0] hit_way, free_way;
   arpc_pkg::entry_type        ent;
   arpc_pkg::row_type          row_mod;
   arpc_pkg::rsp_type          res;
   logic [3:0]                 retry_eff;

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      set_in        = set_ff;
      way_in        = way_ff;
      nib_in        = nib_ff;
      rem_in        = rem_ff;
      row_in        = row_ff;
      valid_in      = valid_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_in        = out_ff;
      cnt_in        = cnt_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_wdata     = row_ff;
      req.ready     = 1'b0;
      emit          = 1'b0;
      res           = '0;
      row_mod       = ram_rdata;
      ent           = row_ff[way_ff];
      retry_eff     = (cfg.retry_count == 4'd0) ? 4'd1 : cfg.retry_count;

      out_free     = !out_valid_ff || rsp.ready;
      out_valid_in = out_valid_ff && !rsp.ready;

      key     = (req_ff.op == arpc_pkg::OP_PACKET) ? req_ff.sender_ip : req_ff.query_ip;
      new_key = (req.op == arpc_pkg::OP_PACKET) ? req.sender_ip : req.query_ip;

      nibble   = 4'(key >> (5'd28 - {nib_ff, 2'b00}));
      rem_step = rem_ff;
      for (int i = 3; i >= 0; i--) begin
         rem_step = {rem_step[REM_W-2:0], nibble[i]};
         if (rem_step >= REM_W'(arpc_pkg::BUCKETS)) begin
            rem_step = rem_step - REM_W'(arpc_pkg::BUCKETS);
         end
      end

      hit      = 1'b0;
      hit_way  = '0;
      has_free = 1'b0;
      free_way = '0;
      for (int w = arpc_pkg::WAYS - 1; w >= 0; w--) begin
         if (valid_ff[set_ff][w] && ram_rdata[w].ip == key) begin
            hit     = 1'b1;
            hit_way = arpc_pkg::WAY_W'(w);
         end
         if (!valid_ff[set_ff][w]) begin
            has_free = 1'b1;
            free_way = arpc_pkg::WAY_W'(w);
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               req_in.op            = req.op;
               req_in.arp_oper      = req.arp_oper;
               req_in.frame_src_mac = req.frame_src_mac;
               req_in.sender_mac    = req.sender_mac;
               req_in.sender_ip     = req.sender_ip;
               req_in.tgt_ip        = req.tgt_ip;
               req_in.query_ip      = req.query_ip;
               cnt_in               = '0;
               if (req.op == arpc_pkg::OP_TICK) begin
                  set_in   = '0;
                  state_in = S_RD;
               end else if (arpc_pkg::BUCKETS_POW2) begin
                  set_in   = new_key[arpc_pkg::SET_W-1:0];
                  state_in = S_RD;
               end else begin
                  rem_in   = '0;
                  nib_in   = '0;
                  state_in = S_MOD;
               end
            end
         end
         S_MOD: begin
            rem_in = rem_step;
            nib_in = nib_ff + 3'd1;
            if (nib_ff == 3'd7) begin
               set_in   = rem_step[arpc_pkg::SET_W-1:0];
               state_in = S_RD;
            end
         end
         S_RD: begin
            ram_re   = 1'b1;
            state_in = (req_ff.op == arpc_pkg::OP_TICK) ? S_TLOAD : S_LOOK;
         end
         S_LOOK: begin
            unique case (req_ff.op)
               arpc_pkg::OP_PACKET: begin
                  if (req_ff.arp_oper == arpc_pkg::OPER_REQUEST) begin
                     if (req_ff.tgt_ip == cfg.own_ip) begin
                        emit                 = 1'b1;
                        res.kind             = arpc_pkg::K_REPLY;
                        res.reply_target_mac = req_ff.sender_mac;
                        res.reply_dst_ip     = req_ff.sender_ip;
                     end
                  end else if (req_ff.arp_oper == arpc_pkg::OPER_REPLY) begin
                     if (hit) begin
                        row_mod[hit_way].mac     = req_ff.frame_src_mac;
                        row_mod[hit_way].status  = arpc_pkg::ST_RESOLVED;
                        row_mod[hit_way].retries = 4'd0;
                        row_mod[hit_way].waiter  = 1'b0;
                        ram_we                   = 1'b1;
                        if (ram_rdata[hit_way].waiter) begin
                           emit            = 1'b1;
                           res.kind        = arpc_pkg::K_RESOLVED;
                           res.entry_ip    = req_ff.sender_ip;
                           res.entry_mac   = req_ff.frame_src_mac;
                           res.entry_state = arpc_pkg::ST_RESOLVED;
                        end
                     end else if (has_free) begin
                        row_mod[free_way].ip       = req_ff.sender_ip;
                        row_mod[free_way].mac      = req_ff.frame_src_mac;
                        row_mod[free_way].status   = arpc_pkg::ST_RESOLVED;
                        row_mod[free_way].retries  = 4'd0;
                        row_mod[free_way].waiter   = 1'b0;
                        ram_we                     = 1'b1;
                        valid_in[set_ff][free_way] = 1'b1;
                     end else begin
                        emit         = 1'b1;
                        res.kind     = arpc_pkg::K_FULL;
                        res.entry_ip = req_ff.sender_ip;
                     end
                  end
               end
               arpc_pkg::OP_QUERY: begin
                  if (hit) begin
                     emit            = 1'b1;
                     res.kind        = arpc_pkg::K_PRESENT;
                     res.entry_ip    = req_ff.query_ip;
                     res.entry_mac   = ram_rdata[hit_way].mac;
                     res.entry_state = ram_rdata[hit_way].status;
                  end else if (has_free) begin
                     row_mod[free_way].ip       = req_ff.query_ip;
                     row_mod[free_way].mac      = '0;
                     row_mod[free_way].status   = arpc_pkg::ST_INCOMPLETE;
                     row_mod[free_way].retries  = retry_eff;
                     row_mod[free_way].waiter   = 1'b1;
                     ram_we                     = 1'b1;
                     valid_in[set_ff][free_way] = 1'b1;
                  end else begin
                     emit         = 1'b1;
                     res.kind     = arpc_pkg::K_FULL;
                     res.entry_ip = req_ff.query_ip;
                  end
               end
               default: begin
                  emit         = 1'b1;
                  res.kind     = arpc_pkg::K_LOOKUP;
                  res.entry_ip = req_ff.query_ip;
                  if (hit) begin
                     res.entry_mac   = ram_rdata[hit_way].mac;
                     res.entry_state = ram_rdata[hit_way].status;
                  end
               end
            endcase
            ram_wdata = row_mod;
            if (emit) begin
               pend_in       = res;
               pend_valid_in = 1'b1;
            end
            state_in = S_FLUSH;
         end
         S_TLOAD: begin
            row_in   = ram_rdata;
            way_in   = '0;
            state_in = S_TWAY;
         end
         S_TWAY: begin
            if (valid_ff[set_ff][way_ff]) begin
               if (ent.status == arpc_pkg::ST_INCOMPLETE) begin
                  ent.retries = ent.retries - 4'd1;
                  if (ent.retries == 4'd0) begin
                     ent.status = arpc_pkg::ST_FAILED;
                  end
               end
               if (ent.status == arpc_pkg::ST_FAILED && ent.waiter &&
                   cnt_ff < arpc_pkg::CNT_W'(arpc_pkg::MAX_RESULTS)) begin
                  emit = 1'b1;
               end
            end
            if (!(emit && pend_valid_ff && !out_free)) begin
               if (emit) begin
                  if (pend_valid_ff) begin
                     out_in       = pend_ff;
                     out_valid_in = 1'b1;
                  end
                  res.kind        = arpc_pkg::K_FAILED;
                  res.entry_ip    = ent.ip;
                  res.entry_mac   = ent.mac;
                  res.entry_state = arpc_pkg::ST_FAILED;
                  pend_in         = res;
                  pend_valid_in   = 1'b1;
                  ent.waiter      = 1'b0;
                  cnt_in          = cnt_ff + 1'b1;
               end
               row_in[way_ff] = ent;
               if (way_ff == arpc_pkg::WAY_W'(arpc_pkg::WAYS - 1)) begin
                  state_in = S_TWR;
               end else begin
                  way_in = way_ff + 1'b1;
               end
            end
         end
         S_TWR: begin
            ram_we = 1'b1;
            if (set_ff == arpc_pkg::SET_W'(arpc_pkg::BUCKETS - 1)) begin
               state_in = S_FLUSH;
            end else begin
               set_in   = set_ff + 1'b1;
               state_in = S_RD;
            end
         end
         default: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               out_in        = pend_ff;
               out_in.last   = 1'b1;
               out_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         cnt_ff        <= cnt_in;
      end
      req_ff  <= req_in;
      set_ff  <= set_in;
      way_ff  <= way_in;
      nib_ff  <= nib_in;
      rem_ff  <= rem_in;
      row_ff  <= row_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

endmodule

// ===== verif/arp_cache_and_responder_unit_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// arp_cache_and_responder_unit_test
// Self-checking bench for the ARP cache and responder. A local copy of the
// set-associative table and registers predicts every response of each
// accepted transaction; responses are compared field by field in order.
// Directed tests cover the responder, resolve/lookup/reply flow, full sets,
// retry expiry and register extremes; random traffic on a small address pool
// follows, with random idling, a long response stall and a full drain.
// ============================================================================
module arp_cache_and_responder_unit_test;

   localparam int SLOTS       = arpc_pkg::BUCKETS * arpc_pkg::WAYS;
   localparam int TICK_CYCLES = arpc_pkg::BUCKETS * (arpc_pkg::WAYS + 3) + 2;
   localparam int SETTLE      = TICK_CYCLES + 20;
   localparam int LIMIT       = 600000;

   logic clock;
   logic reset;

   arpc_req_if req_ch ();
   arpc_rsp_if rsp_ch ();
   arpc_csr_if csr_ch ();

   arp_cache_and_responder_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // local table and registers
   logic                tbl_valid [SLOTS];
   arpc_pkg::entry_type tbl_entry [SLOTS];
   logic [31:0]         cur_own_ip;
   logic [47:0]         cur_own_mac;
   logic [3:0]          cur_retry;

   arpc_pkg::rsp_type   expected_rsp [$];
   int                  errors;
   int                  cycles;
   bit                  tx_gaps_on;
   bit                  rx_gaps_on;
   int                  rx_hold;
   int                  rx_stall_left;
   logic [31:0]         ip_pool [24];

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic report(input string field, input logic [47:0] want, input logic [47:0] got);
      $display("mismatch %s: expected %0h got %0h (cycle %0d)", field, want, got, cycles);
      errors++;
   endtask

   function automatic void add_result(input logic [2:0] kind, input logic [47:0] rmac,
                                      input logic [31:0] rip, input logic [31:0] eip,
                                      input logic [47:0] emac, input logic [1:0] est);
      arpc_pkg::rsp_type r;
      r.kind             = kind;
      r.reply_target_mac = rmac;
      r.reply_dst_ip     = rip;
      r.entry_ip         = eip;
      r.entry_mac        = emac;
      r.entry_state      = est;
      r.last             = 1'b0;
      expected_rsp.push_back(r);
   endfunction

   function automatic int find_entry(input logic [31:0] ip);
      int base;
      base = int'(ip % arpc_pkg::BUCKETS) * arpc_pkg::WAYS;
      for (int w = 0; w < arpc_pkg::WAYS; w++)
         if (tbl_valid[base + w] && tbl_entry[base + w].ip == ip) return base + w;
      return -1;
   endfunction

   function automatic int free_entry(input logic [31:0] ip);
      int base;
      base = int'(ip % arpc_pkg::BUCKETS) * arpc_pkg::WAYS;
      for (int w = 0; w < arpc_pkg::WAYS; w++)
         if (!tbl_valid[base + w]) return base + w;
      return -1;
   endfunction

   function automatic void arp_table_apply(input arpc_pkg::req_type t);
      int s;
      int n0;
      int cnt;
      n0  = expected_rsp.size();
      cnt = 0;
      case (t.op)
         arpc_pkg::OP_PACKET: begin
            if (t.arp_oper == arpc_pkg::OPER_REQUEST) begin
               if (t.tgt_ip == cur_own_ip)
                  add_result(arpc_pkg::K_REPLY, t.sender_mac, t.sender_ip, '0, '0,
                             arpc_pkg::ST_ABSENT);
            end else if (t.arp_oper == arpc_pkg::OPER_REPLY) begin
               s = find_entry(t.sender_ip);
               if (s >= 0) begin
                  tbl_entry[s].mac     = t.frame_src_mac;
                  tbl_entry[s].status  = arpc_pkg::ST_RESOLVED;
                  tbl_entry[s].retries = '0;
                  if (tbl_entry[s].waiter) begin
                     tbl_entry[s].waiter = 1'b0;
                     add_result(arpc_pkg::K_RESOLVED, '0, '0, t.sender_ip, t.frame_src_mac,
                                arpc_pkg::ST_RESOLVED);
                  end
               end else begin
                  s = free_entry(t.sender_ip);
                  if (s >= 0) begin
                     tbl_valid[s] = 1'b1;
                     tbl_entry[s] = '{ip: t.sender_ip, mac: t.frame_src_mac,
                                      status: arpc_pkg::ST_RESOLVED, retries: 4'd0,
                                      waiter: 1'b0};
                  end else
                     add_result(arpc_pkg::K_FULL, '0, '0, t.sender_ip, '0, arpc_pkg::ST_ABSENT);
               end
            end
         end
         arpc_pkg::OP_QUERY: begin
            s = find_entry(t.query_ip);
            if (s >= 0)
               add_result(arpc_pkg::K_PRESENT, '0, '0, t.query_ip, tbl_entry[s].mac,
                          tbl_entry[s].status);
            else begin
               s = free_entry(t.query_ip);
               if (s >= 0) begin
                  tbl_valid[s] = 1'b1;
                  tbl_entry[s] = '{ip: t.query_ip, mac: 48'd0, status: arpc_pkg::ST_INCOMPLETE,
                                   retries: (cur_retry == 4'd0) ? 4'd1 : cur_retry,
                                   waiter: 1'b1};
               end else
                  add_result(arpc_pkg::K_FULL, '0, '0, t.query_ip, '0, arpc_pkg::ST_ABSENT);
            end
         end
         arpc_pkg::OP_LOOKUP: begin
            s = find_entry(t.query_ip);
            if (s >= 0)
               add_result(arpc_pkg::K_LOOKUP, '0, '0, t.query_ip, tbl_entry[s].mac,
                          tbl_entry[s].status);
            else
               add_result(arpc_pkg::K_LOOKUP, '0, '0, t.query_ip, '0, arpc_pkg::ST_ABSENT);
         end
         default: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (!tbl_valid[i]) continue;
               if (tbl_entry[i].status == arpc_pkg::ST_INCOMPLETE) begin
                  tbl_entry[i].retries = tbl_entry[i].retries - 4'd1;
                  if (tbl_entry[i].retries == 4'd0) tbl_entry[i].status = arpc_pkg::ST_FAILED;
               end
               if (tbl_entry[i].status == arpc_pkg::ST_FAILED && tbl_entry[i].waiter &&
                   cnt < arpc_pkg::MAX_RESULTS) begin
                  tbl_entry[i].waiter = 1'b0;
                  cnt++;
                  add_result(arpc_pkg::K_FAILED, '0, '0, tbl_entry[i].ip, tbl_entry[i].mac,
                             arpc_pkg::ST_FAILED);
               end
            end
         end
      endcase
      if (expected_rsp.size() > n0) expected_rsp[expected_rsp.size() - 1].last = 1'b1;
   endfunction

   task automatic send_item(input arpc_pkg::req_type t);
      if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.op            <= t.op;
      req_ch.arp_oper      <= t.arp_oper;
      req_ch.frame_src_mac <= t.frame_src_mac;
      req_ch.sender_mac    <= t.sender_mac;
      req_ch.sender_ip     <= t.sender_ip;
      req_ch.tgt_ip        <= t.tgt_ip;
      req_ch.query_ip      <= t.query_ip;
      do @(posedge clock); while (!req_ch.ready);
      arp_table_apply(t);
   endtask

   task automatic go_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      go_idle();
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [47:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      case (idx)
         arpc_pkg::REG_OWN_IP:  cur_own_ip  = value[31:0];
         arpc_pkg::REG_OWN_MAC: cur_own_mac = value;
         default:               cur_retry   = value[3:0];
      endcase
      @(posedge clock);
   endtask

   function automatic arpc_pkg::req_type make_req(input logic [1:0] op,
                                                  input logic [15:0] oper,
                                                  input logic [47:0] fmac,
                                                  input logic [47:0] smac,
                                                  input logic [31:0] sip,
                                                  input logic [31:0] tip,
                                                  input logic [31:0] qip);
      arpc_pkg::req_type t;
      t.op            = op;
      t.arp_oper      = oper;
      t.frame_src_mac = fmac;
      t.sender_mac    = smac;
      t.sender_ip     = sip;
      t.tgt_ip        = tip;
      t.query_ip      = qip;
      return t;
   endfunction

   function automatic logic [47:0] rand48();
      return {16'($urandom_range(0, 16'hFFFF)), $urandom()};
   endfunction

   function automatic logic [31:0] pick_ip();
      if ($urandom_range(0, 7) == 0) return $urandom();
      return ip_pool[$urandom_range(0, 23)];
   endfunction

   function automatic arpc_pkg::req_type random_req();
      arpc_pkg::req_type t;
      int                sel;
      t   = make_req(arpc_pkg::OP_PACKET, arpc_pkg::OPER_REPLY, rand48(), rand48(), pick_ip(),
                     $urandom(), pick_ip());
      sel = $urandom_range(0, 99);
      if (sel < 30) t.op = arpc_pkg::OP_QUERY;
      else if (sel < 50) t.op = arpc_pkg::OP_LOOKUP;
      else if (sel < 60) t.op = arpc_pkg::OP_TICK;
      else if (sel < 75) begin
         t.arp_oper = arpc_pkg::OPER_REQUEST;
         if ($urandom_range(0, 1) == 0) t.tgt_ip = cur_own_ip;
      end else if (sel < 80)
         t.arp_oper = 16'($urandom_range(0, 16'hFFFF));
      return t;
   endfunction

   always @(posedge clock) begin
      arpc_pkg::rsp_type got;
      arpc_pkg::rsp_type want;
      if (rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.kind, rsp_ch.reply_target_mac, rsp_ch.reply_dst_ip,
                 rsp_ch.entry_ip, rsp_ch.entry_mac, rsp_ch.entry_state, rsp_ch.last};
         if (expected_rsp.size() == 0)
            report("unexpected transaction kind", '0, 48'(got.kind));
         else begin
            want = expected_rsp.pop_front();
            if (got.kind != want.kind) report("kind", 48'(want.kind), 48'(got.kind));
            if (got.reply_target_mac != want.reply_target_mac)
               report("reply_target_mac", want.reply_target_mac, got.reply_target_mac);
            if (got.reply_dst_ip != want.reply_dst_ip)
               report("reply_dst_ip", 48'(want.reply_dst_ip), 48'(got.reply_dst_ip));
            if (got.entry_ip != want.entry_ip)
               report("entry_ip", 48'(want.entry_ip), 48'(got.entry_ip));
            if (got.entry_mac != want.entry_mac)
               report("entry_mac", want.entry_mac, got.entry_mac);
            if (got.entry_state != want.entry_state)
               report("entry_state", 48'(want.entry_state), 48'(got.entry_state));
            if (got.last != want.last) report("last", 48'(want.last), 48'(got.last));
         end
      end
      if (reset) rsp_ch.ready <= 1'b0;
      else if (rx_hold > 0) begin
         rx_hold--;
         rsp_ch.ready <= 1'b0;
      end else if (rx_stall_left > 0) begin
         rx_stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (rx_gaps_on && $urandom_range(0, 5) == 0) begin
         rx_stall_left = $urandom_range(0, 5);
         rsp_ch.ready <= 1'b0;
      end else
         rsp_ch.ready <= 1'b1;
   end

   task automatic test_responder();
      write_reg(arpc_pkg::REG_OWN_IP, 48'hFFFF_FFFF);
      write_reg(arpc_pkg::REG_OWN_MAC, 48'hFFFF_FFFF_FFFF);
      send_item(make_req(arpc_pkg::OP_PACKET, arpc_pkg::OPER_REQUEST, '1, '1, '1,
                         32'hFFFF_FFFF, '1));
      send_item(make_req(arpc_pkg::OP_PACKET, arpc_pkg::OPER_REQUEST, '0, '0, '0,
                         32'hFFFF_FFFE, '0));
      send_item(make_req(arpc_pkg::OP_PACKET, 16'd0, '1, '1, 32'h11, '1, '1));
      send_item(make_req(arpc_pkg::OP_PACKET, 16'hFFFF, '1, '1, 32'h12, '1, '1));
      send_item(make_req(arpc_pkg::OP_PACKET, 16'd3, '1, '1, 32'h13, '1, '1));
      drain();
      write_reg(arpc_pkg::REG_OWN_IP, 48'd0);
      write_reg(arpc_pkg::REG_OWN_MAC, 48'd0);
      send_item(make_req(arpc_pkg::OP_PACKET, arpc_pkg::OPER_REQUEST, '0, 48'h0123_4567_89AB,
                         32'h0A00_0001, '0, '0));
   endtask

   task automatic test_resolve();
      send_item(make_req(arpc_pkg::OP_LOOKUP, '0, '0, '0, '0, '0, 32'hC0A8_0105));
      send_item(make_req(arpc_pkg::OP_QUERY, '0, '0, '0, '0, '0, 32'hC0A8_0105));
      send_item(make_req(arpc_pkg::OP_QUERY, '0, '0, '0, '0, '0, 32'hC0A8_0105));
      send_item(make_req(arpc_pkg::OP_LOOKUP, '0, '0, '0, '0, '0, 32'hC0A8_0105));
      send_item(make_req(arpc_pkg::OP_PACKET, arpc_pkg::OPER_REPLY, '1, 48'h5,
                         32'hC0A8_0105, '0, '0));
      send_item(make_req(arpc_pkg::OP_PACKET, arpc_pkg::OPER_REPLY, 48'hA5A5, 48'h5,
                         32'hC0A8_0105, '0, '0));
      send_item(make_req(arpc_pkg::OP_LOOKUP, '0, '0, '0, '0, '0, 32'hC0A8_0105));
   endtask

   task automatic test_full_set();
      for (int i = 0; i < arpc_pkg::WAYS + 1; i++)
         send_item(make_req(arpc_pkg::OP_QUERY, '0, '0, '0, '0, '0,
                            32'h0000_0007 + 32'(i * arpc_pkg::BUCKETS) + 32'h100));
      send_item(make_req(arpc_pkg::OP_PACKET, arpc_pkg::OPER_REPLY, 48'h77, '0,
                         32'hFFFF_FFF7, '0, '0));
   endtask

   task automatic test_expiry();
      drain();
      write_reg(arpc_pkg::REG_RETRY_COUNT, 48'd1);
      send_item(make_req(arpc_pkg::OP_QUERY, '0, '0, '0, '0, '0, 32'h0000_0002));
      send_item(make_req(arpc_pkg::OP_TICK, '0, '0, '0, '0, '0, '0));
      send_item(make_req(arpc_pkg::OP_PACKET, arpc_pkg::OPER_REPLY, 48'h22, '0,
                         32'h0000_0002, '0, '0));
      drain();
      write_reg(arpc_pkg::REG_RETRY_COUNT, 48'd0);
      send_item(make_req(arpc_pkg::OP_QUERY, '0, '0, '0, '0, '0, 32'h0000_0003));
      send_item(make_req(arpc_pkg::OP_TICK, '0, '0, '0, '0, '0, '0));
      send_item(make_req(arpc_pkg::OP_TICK, '0, '0, '0, '0, '0, '0));
      drain();
      write_reg(arpc_pkg::REG_RETRY_COUNT, 48'd15);
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) send_item(random_req());
   endtask

   task automatic test_backpressure();
      drain();
      rx_hold = 400;
      for (int i = 0; i < 20; i++)
         send_item(make_req(arpc_pkg::OP_LOOKUP, '0, '0, '0, '0, '0, pick_ip()));
      drain();
   endtask

   initial begin
      errors        = 0;
      cycles        = 0;
      rx_hold       = 0;
      rx_stall_left = 0;
      tx_gaps_on    = 1'b1;
      rx_gaps_on    = 1'b1;
      cur_own_ip    = '0;
      cur_own_mac   = '0;
      cur_retry     = 4'd7;
      for (int i = 0; i < SLOTS; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_entry[i] = '0;
      end
      for (int i = 0; i < 24; i++) ip_pool[i] = $urandom();
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.op            <= arpc_pkg::OP_PACKET;
      req_ch.arp_oper      <= '0;
      req_ch.frame_src_mac <= '0;
      req_ch.sender_mac    <= '0;
      req_ch.sender_ip     <= '0;
      req_ch.tgt_ip        <= '0;
      req_ch.query_ip      <= '0;
      csr_ch.valid         <= 1'b0;
      csr_ch.index         <= arpc_pkg::REG_OWN_IP;
      csr_ch.data          <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_responder();
      test_resolve();
      test_full_set();
      test_expiry();

      test_random(25);
      drain();
      write_reg(arpc_pkg::REG_OWN_IP, {16'd0, ip_pool[3]});
      write_reg(arpc_pkg::REG_OWN_MAC, rand48());
      write_reg(arpc_pkg::REG_RETRY_COUNT, 48'd3);
      test_backpressure();
      test_random(25);
      drain();
      write_reg(arpc_pkg::REG_RETRY_COUNT, 48'd2);
      tx_gaps_on = 1'b0;
      rx_gaps_on = 1'b0;
      test_random(15);

      go_idle();
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0 && expected_rsp.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/arpc_pkg.sv
src/arpc_if.sv
src/arpc_cfg.sv
src/arpc_set_ram.sv
src/arp_cache_and_responder_unit.sv
verif/arp_cache_and_responder_unit_test.sv
